### design/fat16_cluster_table_engine_macros.svh
`ifndef FAT16_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT16_CLUSTER_TABLE_ENGINE_MACROS_SVH

// checks that only hold out of reset
`define FCTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checks that hold at every edge, reset included
`define FCTE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/fcte_pkg.sv
package fcte_pkg;

	localparam int CLUSTERS_DEF = 4096;
	localparam int FIRST_DATA   = 2;

	localparam int OP_W      = 2;
	localparam int CL_W      = 16;
	localparam int VAL_W     = 16;
	localparam int ALLOC_W   = 12;
	localparam int FREED_W   = 13;
	localparam int ST_W      = 2;
	localparam int TOT_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int CMP_W     = 17;

	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
	localparam logic [ST_W-1:0] ST_LONG  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EOF   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RSV   = 2'd2;

	localparam logic [TOT_W-1:0] TOTAL_RST = 12'd4094;
	localparam logic [CFG_W-1:0] EOF_RST   = 16'd65535;
	localparam logic [CFG_W-1:0] RSV_RST   = 16'd65520;

	typedef logic [1:0] wr_sel_t;
	localparam wr_sel_t WR_CLEAR = 2'd0;
	localparam wr_sel_t WR_PORT  = 2'd1;
	localparam wr_sel_t WR_EOF   = 2'd2;
	localparam wr_sel_t WR_ZERO  = 2'd3;

	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_PORT = 2'd0;
	localparam rd_sel_t RD_IDX  = 2'd1;
	localparam rd_sel_t RD_CUR  = 2'd2;

	typedef logic [1:0] res_sel_t;
	localparam res_sel_t RES_NONE  = 2'd0;
	localparam res_sel_t RES_READ  = 2'd1;
	localparam res_sel_t RES_ALLOC = 2'd2;
	localparam res_sel_t RES_FREE  = 2'd3;

	typedef struct packed {
		logic             accept;
		logic             wr_en;
		wr_sel_t          wr_sel;
		rd_sel_t          rd_sel;
		logic             idx_inc;
		logic             walk_step;
		logic             res_load;
		res_sel_t         res_sel;
		logic [ST_W-1:0]  res_status;
	} cmd_t;

	typedef struct packed {
		logic port_in;
		logic cur_out;
		logic clr_last;
		logic scan_end;
		logic rd_zero;
		logic walk_go;
		logic walk_long;
	} sts_t;

endpackage

### design/fcte_ram.sv
module fcte_ram #(
	parameter int W = 16,
	parameter int D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/fcte_ctrl.sv
`include "fat16_cluster_table_engine_macros.svh"

module fcte_ctrl import fcte_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] operation,
	input  sts_t            sts,
	output cmd_t            cmd,
	output logic            busy
);

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_ACHK = 3'd3;
	localparam logic [2:0] S_ATST = 3'd4;
	localparam logic [2:0] S_FCHK = 3'd5;
	localparam logic [2:0] S_FUPD = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_CLR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_CLEAR;
				cmd.idx_inc = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.rd_sel = RD_PORT;
				if (start) begin
					cmd.accept = 1'b1;
					case (operation)
						OP_READ: begin
							state_nxt = S_READ;
						end
						OP_WRITE: begin
							cmd.wr_en      = sts.port_in;
							cmd.wr_sel     = WR_PORT;
							cmd.res_load   = 1'b1;
							cmd.res_sel    = RES_NONE;
							cmd.res_status = sts.port_in ? ST_OK : ST_RANGE;
						end
						OP_ALLOC: begin
							state_nxt = S_ACHK;
						end
						OP_FREE: begin
							state_nxt = S_FCHK;
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.res_load   = 1'b1;
				cmd.res_sel    = RES_READ;
				cmd.res_status = sts.cur_out ? ST_RANGE : ST_OK;
				state_nxt      = S_IDLE;
			end
			S_ACHK: begin
				cmd.rd_sel = RD_IDX;
				if (sts.scan_end) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RES_NONE;
					cmd.res_status = ST_FULL;
					state_nxt      = S_IDLE;
				end else begin
					state_nxt = S_ATST;
				end
			end
			S_ATST: begin
				if (sts.rd_zero) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_sel     = WR_EOF;
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RES_ALLOC;
					cmd.res_status = ST_OK;
					state_nxt      = S_IDLE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nxt   = S_ACHK;
				end
			end
			S_FCHK: begin
				cmd.rd_sel  = RD_CUR;
				cmd.res_sel = RES_FREE;
				if (!sts.walk_go) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					state_nxt      = S_IDLE;
				end else if (sts.cur_out) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_RANGE;
					state_nxt      = S_IDLE;
				end else if (sts.walk_long) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_LONG;
					state_nxt      = S_IDLE;
				end else begin
					state_nxt = S_FUPD;
				end
			end
			S_FUPD: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_ZERO;
				cmd.walk_step = 1'b1;
				state_nxt     = S_FCHK;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

	`FCTE_ASSERT(a_eof_only_free, (cmd.wr_en && cmd.wr_sel == WR_EOF) |-> sts.rd_zero, "allocate wrote a used entry")
	`FCTE_ASSERT(a_long_needs_count, (cmd.res_load && cmd.res_status == ST_LONG) |-> sts.walk_long, "chain cut short")

endmodule

### design/fcte_dp.sv
`include "fat16_cluster_table_engine_macros.svh"

module fcte_dp import fcte_pkg::*; #(
	parameter int CLUSTERS = CLUSTERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic [CL_W-1:0]      cluster,
	input  logic [VAL_W-1:0]     value,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic [VAL_W-1:0]     entry_value,
	output logic [ALLOC_W-1:0]   allocated,
	output logic [FREED_W-1:0]   freed_count,
	output logic [ST_W-1:0]      status,
	output logic                 done
);

	localparam int AW = $clog2(CLUSTERS);
	localparam int IW = AW + 1;

	logic [TOT_W-1:0]   tot_q;
	logic [CFG_W-1:0]   eof_q;
	logic [CFG_W-1:0]   rsv_q;
	logic [CL_W-1:0]    cur_q;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      freed_q;
	logic [VAL_W-1:0]   entry_q;
	logic [ALLOC_W-1:0] alloc_q;
	logic [FREED_W-1:0] fcnt_q;
	logic [ST_W-1:0]    status_q;
	logic               done_q;

	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	logic [VAL_W-1:0] wdata;
	logic [VAL_W-1:0] rdata;

	always_comb begin
		case (cmd.wr_sel)
			WR_CLEAR: begin
				waddr = idx_q[AW-1:0];
				wdata = '0;
			end
			WR_PORT: begin
				waddr = cluster[AW-1:0];
				wdata = value;
			end
			WR_EOF: begin
				waddr = idx_q[AW-1:0];
				wdata = eof_q;
			end
			WR_ZERO: begin
				waddr = cur_q[AW-1:0];
				wdata = '0;
			end
			default: begin
				waddr = idx_q[AW-1:0];
				wdata = '0;
			end
		endcase
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_PORT: raddr = cluster[AW-1:0];
			RD_IDX:  raddr = idx_q[AW-1:0];
			RD_CUR:  raddr = cur_q[AW-1:0];
			default: raddr = idx_q[AW-1:0];
		endcase
	end

	fcte_ram #(
		.W(VAL_W),
		.D(CLUSTERS)
	) u_table (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		sts.port_in   = CMP_W'(cluster) < CMP_W'(CLUSTERS);
		sts.cur_out   = CMP_W'(cur_q) >= CMP_W'(CLUSTERS);
		sts.clr_last  = idx_q == IW'(CLUSTERS - 1);
		sts.scan_end  = (CMP_W'(idx_q) >= CMP_W'(tot_q) + CMP_W'(FIRST_DATA))
			|| (CMP_W'(idx_q) >= CMP_W'(CLUSTERS));
		sts.rd_zero   = rdata == '0;
		sts.walk_go   = (cur_q >= CL_W'(FIRST_DATA)) && (cur_q < rsv_q);
		sts.walk_long = freed_q >= IW'(CLUSTERS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= TOTAL_RST;
			eof_q <= EOF_RST;
			rsv_q <= RSV_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TOTAL: tot_q <= cfg_data[TOT_W-1:0];
				CFG_EOF:   eof_q <= cfg_data;
				CFG_RSV:   rsv_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
			if (cmd.accept) begin
				idx_q <= IW'(FIRST_DATA);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_q   <= cluster;
			freed_q <= '0;
		end else if (cmd.walk_step) begin
			cur_q   <= rdata;
			freed_q <= freed_q + IW'(1);
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			entry_q  <= (cmd.res_sel == RES_READ && cmd.res_status == ST_OK) ? rdata : '0;
			alloc_q  <= (cmd.res_sel == RES_ALLOC) ? ALLOC_W'(idx_q) : '0;
			fcnt_q   <= (cmd.res_sel == RES_FREE) ? FREED_W'(freed_q) : '0;
		end
	end

	assign entry_value = entry_q;
	assign allocated   = alloc_q;
	assign freed_count = fcnt_q;
	assign status      = status_q;
	assign done        = done_q;

	`FCTE_ASSERT(a_done_follows_load, done_q |-> $past(cmd.res_load), "stray result strobe")
	`FCTE_ASSERT(a_full_zero, (done_q && status_q == ST_FULL) |-> (alloc_q == '0 && fcnt_q == '0 && entry_q == '0), "full result not zero")

endmodule

### design/fat16_cluster_table_engine.sv
// FAT16 allocation table engine: CLUSTERS 16-bit entries, all free after reset.
// Request channel: operation, cluster and value are taken at a rising edge with
// start high and busy low. Operations: read entry, write entry, allocate the
// first free entry from index 2 (marked with eof_marker), free a chain.
// Result channel: entry_value, allocated, freed_count and status stand for one
// cycle under done; the receiver cannot stall, so each result must be taken then.
// Path from the accepting edge to done: write ends in S_IDLE, read passes S_READ,
// allocate passes S_ACHK (read) and S_ATST (test) per scanned entry until a free
// one is marked or the scan ends, free passes S_FCHK (check) and S_FUPD
// (write-back) per entry freed and ends in S_FCHK. The table read is registered,
// so each entry takes a read state and a test or write-back state. done rises in
// the cycle busy falls, so the next request can be taken while a result is shown.
// Configuration: cfg_write with cfg_index and cfg_data, one cycle, any time the
// engine is idle. Reset: registers take their defaults and the table is swept
// to zero one entry a cycle, with busy high throughout.
`include "fat16_cluster_table_engine_macros.svh"

module fat16_cluster_table_engine import fcte_pkg::*; #(
	parameter int CLUSTERS = CLUSTERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [OP_W-1:0]      operation,
	input  logic [CL_W-1:0]      cluster,
	input  logic [VAL_W-1:0]     value,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 done,
	output logic [VAL_W-1:0]     entry_value,
	output logic [ALLOC_W-1:0]   allocated,
	output logic [FREED_W-1:0]   freed_count,
	output logic [ST_W-1:0]      status
);

	cmd_t cmd;
	sts_t sts;

	fcte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	fcte_dp #(
		.CLUSTERS(CLUSTERS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cluster     (cluster),
		.value       (value),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.entry_value (entry_value),
		.allocated   (allocated),
		.freed_count (freed_count),
		.status      (status),
		.done        (done)
	);

	`FCTE_ASSERT_ALWAYS(a_done_when_idle, done |-> !busy, "result shown while busy")

endmodule
